/* sv/sppm_rfu_pkg.sv */
// shared constants, stage types and step functions for the radius and flux update
package sppm_rfu_pkg;

    localparam logic [15:0] GAMMA_RESET = 16'd43691;
    localparam int DIV_STAGES  = 15;
    localparam int SQRT_STAGES = 12;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

    // restoring divider state: partial remainder and quotient so far
    typedef struct packed {
        logic [40:0] rem;
        logic [30:0] quo;
    } div_t;

    // digit-by-digit square root state
    typedef struct packed {
        logic [25:0] rem;
        logic [23:0] root;
        logic [47:0] val;
    } sqrt_t;

    // one quotient bit
    function automatic div_t div_step(input div_t s, input logic [40:0] den);
        logic [41:0] sh;
        div_t        o;
        sh    = {s.rem, 1'b0};
        o.quo = {s.quo[29:0], 1'b0};
        if (sh >= {1'b0, den})
        begin
            o.rem    = 41'(sh - {1'b0, den});
            o.quo[0] = 1'b1;
        end
        else
        begin
            o.rem = sh[40:0];
        end
        return o;
    endfunction

    // one root bit, consumes two radicand bits
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        logic [27:0] sh;
        logic [27:0] trial;
        sqrt_t       o;
        sh    = {s.rem, s.val[47:46]};
        trial = {2'b00, s.root, 2'b01};
        o.val = {s.val[45:0], 2'b00};
        if (sh >= trial)
        begin
            o.rem  = 26'(sh - trial);
            o.root = {s.root[22:0], 1'b1};
        end
        else
        begin
            o.rem  = sh[25:0];
            o.root = {s.root[22:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* sv/sppm_radius_flux_update.sv */
// radius and flux update for one visible point per cycle, fully pipelined
//
//  channel  | ports                                        | timing
//  ---------+----------------------------------------------+---------------------------
//  config   | cfg_we, shrink_gamma                         | written at edge with cfg_we
//  input    | start, busy, accum_count .. power_blue       | taken when start && !busy
//  result   | done, new_count .. new_flux_blue             | one cycle, strobed by done
//
// every transaction passes from the accepting edge to the edge that takes its result
// through one setup stage, one first quotient bit, 15 divider stages of two
// quotient bits, one multiply, one combine stage and 12 square root stages of two
// root bits each
// a new transaction can enter every cycle; busy stays low
// reset clears the valid bits and restores shrink_gamma to two thirds
// the receiver cannot stall, so the pipeline always advances
module sppm_radius_flux_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] shrink_gamma,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] accum_count,
    input  logic [19:0] pass_count,
    input  logic [23:0] radius,
    input  logic [31:0] flux_red,
    input  logic [31:0] flux_green,
    input  logic [31:0] flux_blue,
    input  logic [15:0] through_red,
    input  logic [15:0] through_green,
    input  logic [15:0] through_blue,
    input  logic [31:0] power_red,
    input  logic [31:0] power_green,
    input  logic [31:0] power_blue,
    output logic        done,
    output logic [31:0] new_count,
    output logic [23:0] new_radius,
    output logic [31:0] new_flux_red,
    output logic [31:0] new_flux_green,
    output logic [31:0] new_flux_blue
);

    localparam int DS = sppm_rfu_pkg::DIV_STAGES;
    localparam int SS = sppm_rfu_pkg::SQRT_STAGES;

    // configuration register
    logic [15:0] gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= sppm_rfu_pkg::GAMMA_RESET;
        else if (cfg_we)
            gamma_reg <= shrink_gamma;
    end

    assign busy = 1'b0;

    // per channel views of the input ports
    logic [31:0] tau_in  [0:2];
    logic [15:0] beta_in [0:2];
    logic [31:0] phi_in  [0:2];

    assign tau_in[0]  = flux_red;
    assign tau_in[1]  = flux_green;
    assign tau_in[2]  = flux_blue;
    assign beta_in[0] = through_red;
    assign beta_in[1] = through_green;
    assign beta_in[2] = through_blue;
    assign phi_in[0]  = power_red;
    assign phi_in[1]  = power_green;
    assign phi_in[2]  = power_blue;

    // stage 1: N' and N+M in Q.16, r squared, beta times phi
    logic        s1_valid_reg;
    logic [40:0] s1_num_reg;
    logic [40:0] s1_den_reg;
    logic [47:0] s1_rr_reg;
    logic [47:0] s1_bp_reg  [0:2];
    logic [31:0] s1_tau_reg [0:2];

    logic [35:0] gm_next;
    assign gm_next = 36'(gamma_reg) * 36'(pass_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_num_reg <= {1'b0, accum_count, 8'h00} + 41'(gm_next);
        s1_den_reg <= {1'b0, accum_count, 8'h00} + {5'b0, pass_count, 16'h0000};
        s1_rr_reg  <= 48'(radius) * 48'(radius);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_s1
        always_ff @(posedge clk)
        begin
            s1_bp_reg[c]  <= 48'(beta_in[c]) * 48'(phi_in[c]);
            s1_tau_reg[c] <= tau_in[c];
        end
    end

    // divider pipeline, index 0 holds the first quotient bit
    logic                 d_valid_reg [0:DS];
    sppm_rfu_pkg::div_t   d_state_reg [0:DS];
    logic [40:0]          d_den_reg   [0:DS];
    logic                 d_zero_reg  [0:DS];
    logic [31:0]          d_cnt_reg   [0:DS];
    logic [47:0]          d_rr_reg    [0:DS];
    logic [36:0]          d_sum_reg   [0:DS][0:2];

    logic        q0_next;
    logic [32:0] cnt_next;
    assign q0_next  = (s1_num_reg >= s1_den_reg);
    assign cnt_next = s1_num_reg[40:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg[0] <= 1'b0;
        else
            d_valid_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_state_reg[0].quo <= {30'b0, q0_next};
        d_state_reg[0].rem <= q0_next ? 41'(s1_num_reg - s1_den_reg) : s1_num_reg;
        d_den_reg[0]       <= s1_den_reg;
        d_zero_reg[0]      <= (s1_num_reg == 41'b0);
        d_cnt_reg[0]       <= cnt_next[32] ? sppm_rfu_pkg::SAT32 : cnt_next[31:0];
        d_rr_reg[0]        <= s1_rr_reg;
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_sum
        always_ff @(posedge clk)
        begin
            d_sum_reg[0][c] <= 37'(s1_tau_reg[c]) + 37'(s1_bp_reg[c][47:12]);
        end
    end

    for (genvar k = 1; k <= DS; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid_reg[k] <= 1'b0;
            else
                d_valid_reg[k] <= d_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            d_state_reg[k] <= sppm_rfu_pkg::div_step(
                sppm_rfu_pkg::div_step(d_state_reg[k-1], d_den_reg[k-1]),
                d_den_reg[k-1]);
            d_den_reg[k]   <= d_den_reg[k-1];
            d_zero_reg[k]  <= d_zero_reg[k-1];
            d_cnt_reg[k]   <= d_cnt_reg[k-1];
            d_rr_reg[k]    <= d_rr_reg[k-1];
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_ch
            always_ff @(posedge clk)
            begin
                d_sum_reg[k][c] <= d_sum_reg[k-1][c];
            end
        end
    end

    // multiply stage: split partial products by the Q1.30 ratio
    logic [30:0] ratio_next;
    assign ratio_next = d_zero_reg[DS] ? sppm_rfu_pkg::ONE_Q30 : d_state_reg[DS].quo;

    logic        m_valid_reg;
    logic [31:0] m_cnt_reg;
    logic [54:0] m_rr_hi_reg;
    logic [54:0] m_rr_lo_reg;
    logic [54:0] m_f_hi_reg [0:2];
    logic [54:0] m_f_lo_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= d_valid_reg[DS];
    end

    always_ff @(posedge clk)
    begin
        m_cnt_reg   <= d_cnt_reg[DS];
        m_rr_hi_reg <= 55'(d_rr_reg[DS][47:24]) * 55'(ratio_next);
        m_rr_lo_reg <= 55'(d_rr_reg[DS][23:0]) * 55'(ratio_next);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_mul
        always_ff @(posedge clk)
        begin
            m_f_hi_reg[c] <= 55'(d_sum_reg[DS][c][36:24]) * 55'(ratio_next);
            m_f_lo_reg[c] <= 55'(d_sum_reg[DS][c][23:0]) * 55'(ratio_next);
        end
    end

    // combine stage: merge partial products, drop 30 fraction bits, saturate flux
    logic [78:0] rr_full_next;
    logic [78:0] f_full_next [0:2];
    assign rr_full_next = {m_rr_hi_reg, 24'h000000} + 79'(m_rr_lo_reg);

    // square root pipeline, index 0 holds the scaled r squared
    logic                 q_valid_reg [0:SS];
    sppm_rfu_pkg::sqrt_t  q_state_reg [0:SS];
    logic [31:0]          q_cnt_reg   [0:SS];
    logic [31:0]          q_flux_reg  [0:SS][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg[0] <= 1'b0;
        else
            q_valid_reg[0] <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        q_state_reg[0].rem  <= 26'b0;
        q_state_reg[0].root <= 24'b0;
        q_state_reg[0].val  <= rr_full_next[77:30];
        q_cnt_reg[0]        <= m_cnt_reg;
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_comb
        assign f_full_next[c] = {m_f_hi_reg[c], 24'h000000} + 79'(m_f_lo_reg[c]);

        always_ff @(posedge clk)
        begin
            q_flux_reg[0][c] <= (|f_full_next[c][78:62]) ? sppm_rfu_pkg::SAT32
                                                         : f_full_next[c][61:30];
        end
    end

    for (genvar k = 1; k <= SS; k++)
    begin : g_sqrt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_valid_reg[k] <= 1'b0;
            else
                q_valid_reg[k] <= q_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            q_state_reg[k] <= sppm_rfu_pkg::sqrt_step(
                sppm_rfu_pkg::sqrt_step(q_state_reg[k-1]));
            q_cnt_reg[k]   <= q_cnt_reg[k-1];
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_ch
            always_ff @(posedge clk)
            begin
                q_flux_reg[k][c] <= q_flux_reg[k-1][c];
            end
        end
    end

    // results straight from the last square root stage
    assign done           = q_valid_reg[SS];
    assign new_count      = q_cnt_reg[SS];
    assign new_radius     = q_state_reg[SS].root;
    assign new_flux_red   = q_flux_reg[SS][0];
    assign new_flux_green = q_flux_reg[SS][1];
    assign new_flux_blue  = q_flux_reg[SS][2];

endmodule
